[src/sorted_table_binary_search_unit_assert.svh]
// Assertion macros for the sorted-table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define STBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define STBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[src/stbs_pkg.sv]
// Package: sizes, word types and codes for the sorted-table search unit.
package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Fixed field widths
    localparam int ENTRIES_W = 9;
    localparam int POS_W     = 8;
    localparam int DATA_W    = 32;

    // Counts must hold both the register value and the depth itself
    localparam int CMP_W = (ENTRIES_W > IDX_W + 1) ? ENTRIES_W : IDX_W + 1;
    // Search bounds are signed: the right bound can reach -1
    localparam int BND_W = CMP_W + 1;

    // Item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOB = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [7:0]               entry_index;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             status;
    } t_out_word;

    // Table write port
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } t_wr_port;

endpackage

[src/stbs_table_ram.sv]
// Table memory: one write port, one read port with registered read data.
module stbs_table_ram (
    input  logic                             i_clk,
    input  stbs_pkg::t_wr_port               i_wr,
    input  logic                             i_rd_en,
    input  logic [stbs_pkg::IDX_W-1:0]       i_rd_addr,
    output logic [stbs_pkg::DATA_W-1:0]      o_rd_data
);

    logic [stbs_pkg::DATA_W-1:0] r_mem [stbs_pkg::TABLE_DEPTH];
    logic [stbs_pkg::DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/sorted_table_binary_search_unit.sv]
// Sorted-table search unit: a table of signed 32-bit words with write and
// binary-search words. One word is handled at a time. A write goes from
// acceptance straight to the FINISH state. A search makes P probes, where
// P is at most floor(log2(count)) + 1, so 9 for a full 256-entry table;
// each probe spends PROBE on the table's registered read and CMP on the
// compare and bound update, before FINISH. The input is not ready while a
// word is in progress; the result sits in an output register, so the next
// word is taken as soon as that result is loaded. The entries_used
// register is always ready and must only be written while the unit is
// idle. Table entries have no reset value.
`include "sorted_table_binary_search_unit_assert.svh"

module sorted_table_binary_search_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  stbs_pkg::t_in_word                 i_in_word,
    // Result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output stbs_pkg::t_out_word                o_out_word,
    // entries_used register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stbs_pkg::ENTRIES_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_FINISH
    } t_state;

    t_state                             r_state, n_state;
    logic [stbs_pkg::ENTRIES_W-1:0]     r_entries_used, n_entries_used;
    logic signed [stbs_pkg::BND_W-1:0]  r_left, n_left;
    logic signed [stbs_pkg::BND_W-1:0]  r_right, n_right;
    logic signed [stbs_pkg::BND_W-1:0]  r_mid, n_mid;
    logic signed [stbs_pkg::DATA_W-1:0] r_target, n_target;
    stbs_pkg::t_out_word                r_res, n_res;
    logic                               r_out_valid, n_out_valid;
    stbs_pkg::t_out_word                r_out, n_out;

    logic [stbs_pkg::CMP_W-1:0]         w_count;
    logic [stbs_pkg::CMP_W-1:0]         w_index;
    logic signed [stbs_pkg::BND_W-1:0]  w_mid;
    logic signed [stbs_pkg::BND_W-1:0]  w_left_up;
    logic signed [stbs_pkg::BND_W-1:0]  w_right_dn;
    logic [stbs_pkg::DATA_W-1:0]        w_rd_data;
    logic                               w_rd_en;
    logic                               w_in_acc;
    logic                               w_out_free;
    stbs_pkg::t_wr_port                 w_wr;

    // Active entry count, clamped to the table depth
    always_comb begin
        if (stbs_pkg::CMP_W'(r_entries_used) > stbs_pkg::CMP_W'(stbs_pkg::TABLE_DEPTH)) begin
            w_count = stbs_pkg::CMP_W'(stbs_pkg::TABLE_DEPTH);
        end else begin
            w_count = stbs_pkg::CMP_W'(r_entries_used);
        end
    end

    assign w_index    = stbs_pkg::CMP_W'(i_in_word.entry_index);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Probe point; right >= left whenever it is used
    assign w_mid      = r_left + ((r_right - r_left) >>> 1);
    assign w_left_up  = r_mid + stbs_pkg::BND_W'(1);
    assign w_right_dn = r_mid - stbs_pkg::BND_W'(1);

    // Table write on an accepted in-range write word
    always_comb begin
        w_wr.en   = w_in_acc && (i_in_word.kind == stbs_pkg::KIND_WRITE)
                    && (w_index < w_count);
        w_wr.addr = stbs_pkg::IDX_W'(i_in_word.entry_index);
        w_wr.data = i_in_word.value;
    end

    assign w_rd_en = (r_state == ST_PROBE);

    stbs_table_ram u_table (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_mid[stbs_pkg::IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Sequencer next state
    always_comb begin
        n_state        = r_state;
        n_entries_used = r_entries_used;
        n_left         = r_left;
        n_right        = r_right;
        n_mid          = r_mid;
        n_target       = r_target;
        n_res          = r_res;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out          = r_out;

        if (i_cfg_valid) begin
            n_entries_used = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_res.found    = 1'b0;
                    n_res.position = '0;
                    n_res.status   = stbs_pkg::STATUS_OK;
                    n_target       = i_in_word.value;
                    n_left         = '0;
                    n_right        = stbs_pkg::BND_W'(w_count) - stbs_pkg::BND_W'(1);
                    if (i_in_word.kind == stbs_pkg::KIND_WRITE) begin
                        if (w_index >= w_count) begin
                            n_res.status = stbs_pkg::STATUS_OOB;
                        end
                        n_state = ST_FINISH;
                    end else if (w_count == '0) begin
                        // empty table: immediate miss
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                n_mid   = w_mid;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                priority if ($signed(w_rd_data) == r_target) begin
                    n_res.found    = 1'b1;
                    n_res.position = stbs_pkg::POS_W'(r_mid);
                    n_state        = ST_FINISH;
                end else if ($signed(w_rd_data) < r_target) begin
                    n_left  = w_left_up;
                    n_state = (w_left_up > r_right) ? ST_FINISH : ST_PROBE;
                end else begin
                    n_right = w_right_dn;
                    n_state = (r_left > w_right_dn) ? ST_FINISH : ST_PROBE;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_entries_used <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_entries_used <= n_entries_used;
            r_out_valid    <= n_out_valid;
        end
        r_left   <= n_left;
        r_right  <= n_right;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    // Checks
    `STBS_ASSERT(a_busy_after_accept, w_in_acc |=> !o_in_ready, "ready stayed high after accept")
    `STBS_ASSERT(a_probe_bounds, (r_state == ST_PROBE) |-> (r_left <= r_right), "probe with empty range")
    `STBS_ASSERT(a_oob_no_hit, o_out_valid |-> !(o_out_word.found && (o_out_word.status == stbs_pkg::STATUS_OOB)), "hit reported with out-of-bounds status")
    `STBS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (o_in_ready && !o_out_valid), "not idle after reset")

endmodule

[sim/sorted_table_binary_search_unit_test.sv]
// Testbench for the sorted-table search unit: write and search words checked against a predictor.
`timescale 1ns / 100ps

// Tracks the table and entry count, predicts each result word and checks results in order.
class search_table_model;
    logic signed [stbs_pkg::DATA_W-1:0] entries [stbs_pkg::TABLE_DEPTH];
    bit                                 filled  [stbs_pkg::TABLE_DEPTH];
    int unsigned                        entries_used;
    stbs_pkg::t_out_word                answers_due [$];
    int                                 errors;

    function new();
        entries_used = 0;
        errors = 0;
        foreach (filled[i]) begin
            filled[i] = 1'b0;
            entries[i] = '0;
        end
    endfunction

    // A count above the depth acts as the depth
    function int unsigned active();
        return (entries_used > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : entries_used;
    endfunction

    // Binary search over the live entries; returns 0 if it probes an unwritten entry
    function bit walk(input logic signed [stbs_pkg::DATA_W-1:0] target, output bit hit,
                      output logic [stbs_pkg::POS_W-1:0] pos);
        int left;
        int right;
        int mid;
        bit safe;
        left = 0;
        right = int'(active()) - 1;
        hit = 1'b0;
        pos = '0;
        safe = 1'b1;
        while (left <= right && !hit) begin
            mid = left + (right - left) / 2;
            if (!filled[mid]) safe = 1'b0;
            if (entries[mid] == target) begin
                hit = 1'b1;
                pos = mid[stbs_pkg::POS_W-1:0];
            end else if (entries[mid] < target) begin
                left = mid + 1;
            end else begin
                right = mid - 1;
            end
        end
        return safe;
    endfunction

    // Accepted input word: update the table and queue the answer it must give
    function void note_word(stbs_pkg::t_in_word w);
        stbs_pkg::t_out_word          ans;
        bit                           hit;
        logic [stbs_pkg::POS_W-1:0]   pos;
        ans = '0;
        if (w.kind == stbs_pkg::KIND_WRITE) begin
            if (w.entry_index < active()) begin
                entries[w.entry_index] = w.value;
                filled[w.entry_index] = 1'b1;
                ans.status = stbs_pkg::STATUS_OK;
            end else begin
                ans.status = stbs_pkg::STATUS_OOB;
            end
        end else begin
            void'(walk($signed(w.value), hit, pos));
            ans.found = hit;
            ans.position = pos;
            ans.status = stbs_pkg::STATUS_OK;
        end
        answers_due.push_back(ans);
    endfunction

    // Accepted result word: compare with the oldest answer due
    function void check_word(stbs_pkg::t_out_word got);
        stbs_pkg::t_out_word want;
        if (answers_due.size() == 0) begin
            $error("result word with nothing due: found=%0d position=%0d status=%0d",
                   got.found, got.position, got.status);
            errors++;
            return;
        end
        want = answers_due.pop_front();
        if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            errors++;
        end
        if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
    endfunction
endclass

module sorted_table_binary_search_unit_test;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     HOLD_CYCLES    = 250;
    localparam int     ITEM_GOAL      = 1100;
    localparam int     IDLE_PCT       = 10;
    localparam longint HALF_RANGE     = 64'sd2147483648;

    localparam logic signed [stbs_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    stbs_pkg::t_in_word             i_in_word   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    stbs_pkg::t_out_word            o_out_word;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [stbs_pkg::ENTRIES_W-1:0] i_cfg_data  = '0;

    search_table_model tracker = new();

    bit quiet        = 1'b0;
    bit hold_results = 1'b0;
    bit pressed      = 1'b0;
    int sent         = 0;
    int idle_cycles  = 0;

    sorted_table_binary_search_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random back-pressure, plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                hold_results = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_word(o_out_word);
    end

    // Watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_table_binary_search_unit_test: errors");
            $finish;
        end
    end

    function automatic bit sender_pauses();
        return !quiet && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic stbs_pkg::t_in_word make_word(logic kind, logic [7:0] idx,
                                                     logic signed [stbs_pkg::DATA_W-1:0] val);
        stbs_pkg::t_in_word w;
        w.kind = kind;
        w.entry_index = idx;
        w.value = val;
        return w;
    endfunction

    // Offer one input word, hold it until accepted, then maybe pause
    task automatic send_word(stbs_pkg::t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_word(w);
        sent++;
        if (sender_pauses()) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (sender_pauses());
        end
    endtask

    task automatic put(int idx, logic signed [stbs_pkg::DATA_W-1:0] v);
        send_word(make_word(stbs_pkg::KIND_WRITE, idx[7:0], v));
    endtask

    // Search only where every probe lands on a written entry
    task automatic seek(logic signed [stbs_pkg::DATA_W-1:0] v);
        bit                         hit;
        logic [stbs_pkg::POS_W-1:0] pos;
        if (tracker.walk(v, hit, pos)) begin
            send_word(make_word(stbs_pkg::KIND_SEARCH, 8'($urandom), v));
        end
    endtask

    // Wait until every result is back, then write entries_used
    task automatic set_entries_used(logic [stbs_pkg::ENTRIES_W-1:0] v);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.answers_due.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.entries_used = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Write entries 0..c-1 in non-decreasing order, one slot of the value range each
    task automatic fill_sorted(int c);
        longint stride;
        longint lo;
        longint v;
        longint prev;
        int     r;
        int     i;
        stride = 64'sd4294967296 / c;
        prev = -HALF_RANGE;
        for (i = 0; i < c; i++) begin
            lo = longint'(i) * stride - HALF_RANGE;
            r = $urandom_range(99);
            if (i > 0 && r < 8) v = prev;           // duplicate keeps order
            else if (r < 14) v = lo;
            else if (r < 20) v = lo + stride - 1;
            else v = lo + longint'($urandom_range(32'(stride - 1)));
            prev = v;
            put(i, v[31:0]);
        end
    endtask

    // One random word against a table of c live entries
    task automatic random_op(int c);
        int r;
        int i;
        r = $urandom_range(99);
        i = (c > 0) ? $urandom_range(c - 1) : 0;
        if (r < 50 && c > 0) begin
            seek(tracker.entries[i]);
        end else if (r < 65) begin
            seek($urandom);
        end else if (r < 75 && c > 0) begin
            seek(tracker.entries[i] + ($urandom_range(1) ? 1 : -1));
        end else if (r < 85) begin
            // out of bounds unless the table is full
            put((c < stbs_pkg::TABLE_DEPTH) ? $urandom_range(255, c) : $urandom_range(255),
                $urandom);
        end else if (r < 93 && c > 0) begin
            put(i, tracker.entries[i]);
        end else begin
            // noise: may break the ordering
            put($urandom_range(255), $urandom);
        end
    endtask

    // New count, fresh sorted contents, then a mix of searches and writes
    task automatic run_phase(bit full);
        int                             r;
        int                             c;
        int                             ops;
        logic [stbs_pkg::ENTRIES_W-1:0] cfg;
        r = $urandom_range(99);
        if (full) cfg = stbs_pkg::ENTRIES_W'(stbs_pkg::TABLE_DEPTH);
        // near the end keep phases short
        else if (sent > ITEM_GOAL - 250) cfg = stbs_pkg::ENTRIES_W'($urandom_range(24, 3));
        else if (r < 5) cfg = 0;
        else if (r < 12) cfg = 1;
        else if (r < 18) cfg = 2;
        else if (r < 24) cfg = stbs_pkg::ENTRIES_W'(stbs_pkg::TABLE_DEPTH);
        else if (r < 28) cfg = '1;
        else if (r < 32) begin
            cfg = stbs_pkg::ENTRIES_W'($urandom_range(511, stbs_pkg::TABLE_DEPTH + 1));
        end
        else cfg = stbs_pkg::ENTRIES_W'($urandom_range(24, 3));
        set_entries_used(cfg);
        c = tracker.active();
        if (c > 0) fill_sorted(c);
        if (!pressed && sent > 300) begin
            hold_results = 1'b1;
            pressed = 1'b1;
        end
        ops = $urandom_range(40, 10);
        repeat (ops) random_op(c);
    endtask

    // Main sequence
    initial begin
        int phase;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: search misses, every write is out of bounds
        seek(0);
        put(0, 5);
        put(255, -1);

        // four entries holding the extremes
        set_entries_used(4);
        put(0, VAL_MIN);
        put(1, -1);
        put(2, 0);
        put(3, VAL_MAX);
        put(4, 7);                  // index equal to count
        seek(VAL_MIN);
        seek(-1);
        seek(0);
        seek(VAL_MAX);
        seek(1);
        seek(-2);

        // unsorted table
        put(1, VAL_MAX);
        seek(-1);
        seek(VAL_MAX);

        // count above depth acts as full depth
        set_entries_used('1);
        put(255, 32'sh1234_5678);
        put(128, 0);

        phase = 0;
        while (sent < ITEM_GOAL) begin
            quiet = (sent >= 500 && sent < 700);
            run_phase(phase == 0);
            phase++;
        end
        quiet = 1'b0;

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.answers_due.size() != 0);
        repeat (40) @(posedge i_clk);
        if (tracker.answers_due.size() != 0) begin
            $error("%0d result words never arrived", tracker.answers_due.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("sorted_table_binary_search_unit_test: clean");
        end else begin
            $display("sorted_table_binary_search_unit_test: errors");
        end
        $finish;
    end

endmodule

[sorted_table_binary_search_unit.f]
+incdir+src
src/stbs_pkg.sv
src/stbs_table_ram.sv
src/sorted_table_binary_search_unit.sv
sim/sorted_table_binary_search_unit_test.sv
